### rtl/core/cc20_pkg.sv
// ----------------------------------------------------------------------------
// ChaCha20 package
// Constants, types and the quarter-round function of the ChaCha20 core.
// ----------------------------------------------------------------------------
package cc20_pkg;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int HALF_ROUNDS   = 2 * DOUBLE_ROUNDS;
    localparam int RND_W         = $clog2(HALF_ROUNDS);
    localparam int BLOCK_BYTES   = 64;
    localparam int LEFT_W        = 7;
    localparam int CFG_IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY01   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY23   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY45   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY67   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTER = 3'd5;

    localparam logic [31:0] SIGMA0 = 32'd1634760805;
    localparam logic [31:0] SIGMA1 = 32'd857760878;
    localparam logic [31:0] SIGMA2 = 32'd2036477234;
    localparam logic [31:0] SIGMA3 = 32'd1797285236;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_WRITE
    } t_gen_state;

    typedef logic [31:0] t_word;

    function automatic t_word rotl(input t_word v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [127:0] qround(input t_word a_i, input t_word b_i,
                                            input t_word c_i, input t_word d_i);
        t_word a, b, c, d;
        a = a_i; b = b_i; c = c_i; d = d_i;
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        qround = {a, b, c, d};
    endfunction

endpackage

### rtl/core/cc20_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module cc20_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/chacha20_stream_cipher.sv
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher
// XORs each data byte with the next keystream byte; 64-bit nonce and counter.
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// in       input      i_valid / o_stall   i_in_byte, i_last_in
// out      output     o_valid / i_stall   o_out_byte, o_last_out
// cfg      input      i_cfg_we            i_cfg_idx, i_cfg_data
//
// One item per cycle while keystream is buffered and i_stall is low;
// items pass the s1 and output registers. An empty buffer stalls a waiting
// item while the core starts, runs the rounds and writes the keystream RAM.
// Reset and key, nonce or counter writes empty the buffer, reload the counter.
// A stalled output holds the pipeline; the RAM read data is held with it.
module chacha20_stream_cipher
    import cc20_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_last_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_out_byte,
    output logic                 o_last_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data
);

    logic [63:0] r_key [4];
    logic [63:0] r_nonce, r_start, r_ctr;
    logic [LEFT_W-1:0] r_left;
    t_gen_state r_state, n_state;
    logic [RND_W-1:0] r_rnd, n_rnd;
    logic [3:0] r_waddr, n_waddr;
    t_word r_work [16];
    t_word n_work [16];
    t_word init_w [16];

    logic r_s1_v, r_out_v;
    logic [7:0] r_s1_byte;
    logic [1:0] r_s1_sel;
    logic r_s1_last;
    logic [7:0] r_out_byte;
    logic r_out_last;

    logic in_acc, s1_move, gen_done, ram_we;
    logic [5:0] pos;
    t_word ram_rdata;
    logic [127:0] qr [4];

    always_comb begin
        init_w[0] = SIGMA0; init_w[1] = SIGMA1;
        init_w[2] = SIGMA2; init_w[3] = SIGMA3;
        for (int i = 0; i < 4; i++) begin
            init_w[4 + 2 * i] = r_key[i][31:0];
            init_w[5 + 2 * i] = r_key[i][63:32];
        end
        init_w[12] = r_ctr[31:0];
        init_w[13] = r_ctr[63:32];
        init_w[14] = r_nonce[31:0];
        init_w[15] = r_nonce[63:32];
    end

    assign s1_move = r_s1_v && (!r_out_v || !i_stall);
    assign o_stall = (r_state != ST_IDLE) || (r_left == '0)
                     || (r_s1_v && !s1_move);
    assign in_acc  = i_valid && !o_stall;
    assign pos     = 6'(BLOCK_BYTES - int'(r_left));
    assign ram_we  = (r_state == ST_WRITE);
    assign gen_done = ram_we && (r_waddr == 4'd15);

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            if (r_rnd[0] == 1'b0) begin
                qr[l] = qround(r_work[l], r_work[4 + l], r_work[8 + l], r_work[12 + l]);
            end else begin
                qr[l] = qround(r_work[l], r_work[4 + ((l + 1) % 4)],
                               r_work[8 + ((l + 2) % 4)], r_work[12 + ((l + 3) % 4)]);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_rnd   = r_rnd;
        n_waddr = r_waddr;
        n_work  = r_work;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && r_left == '0) begin
                    n_state = ST_ROUND;
                    n_rnd   = '0;
                    n_work  = init_w;
                end
            end
            ST_ROUND: begin
                for (int l = 0; l < 4; l++) begin
                    if (r_rnd[0] == 1'b0) begin
                        {n_work[l], n_work[4 + l], n_work[8 + l], n_work[12 + l]} = qr[l];
                    end else begin
                        {n_work[l], n_work[4 + ((l + 1) % 4)], n_work[8 + ((l + 2) % 4)],
                         n_work[12 + ((l + 3) % 4)]} = qr[l];
                    end
                end
                n_rnd = r_rnd + 1'b1;
                if (r_rnd == RND_W'(HALF_ROUNDS - 1)) begin
                    n_state = ST_WRITE;
                    n_waddr = '0;
                end
            end
            ST_WRITE: begin
                n_waddr = r_waddr + 1'b1;
                if (gen_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rnd   <= '0;
            r_waddr <= '0;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
            r_waddr <= n_waddr;
        end
        r_work <= n_work;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_key[i] <= '0;
            r_nonce <= '0;
            r_start <= '0;
            r_ctr   <= '0;
            r_left  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY01, REG_KEY23, REG_KEY45, REG_KEY67: begin
                    r_key[i_cfg_idx[1:0]] <= i_cfg_data;
                    r_ctr  <= r_start;
                    r_left <= '0;
                end
                REG_NONCE: begin
                    r_nonce <= i_cfg_data;
                    r_ctr   <= r_start;
                    r_left  <= '0;
                end
                REG_COUNTER: begin
                    r_start <= i_cfg_data;
                    r_ctr   <= i_cfg_data;
                    r_left  <= '0;
                end
                default: ;
            endcase
        end else if (gen_done) begin
            r_ctr  <= r_ctr + 64'd1;
            r_left <= LEFT_W'(BLOCK_BYTES);
        end else if (in_acc) begin
            r_left <= r_left - 1'b1;
        end
    end

    cc20_ram #(
        .WIDTH(32),
        .DEPTH(16)
    ) u_ks_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_waddr),
        .i_wdata(r_work[r_waddr] + init_w[r_waddr]),
        .i_re   (in_acc),
        .i_raddr(pos[5:2]),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_move) begin
                r_s1_v <= 1'b0;
            end
            if (s1_move) begin
                r_out_v <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
        if (in_acc) begin
            r_s1_byte <= i_in_byte;
            r_s1_last <= i_last_in;
            r_s1_sel  <= pos[1:0];
        end
        if (s1_move) begin
            r_out_byte <= r_s1_byte ^ ram_rdata[8 * r_s1_sel +: 8];
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid    = r_out_v;
    assign o_out_byte = r_out_byte;
    assign o_last_out = r_out_last;

    a_no_acc_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !in_acc)
        else $error("item accepted during block generation");
    a_acc_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_left != '0))
        else $error("item accepted with empty keystream buffer");
    a_write_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |-> (r_left == '0))
        else $error("keystream written while buffer not empty");
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gen_done && !i_cfg_we |=> (r_left == LEFT_W'(BLOCK_BYTES)))
        else $error("buffer not refilled after generation");

endmodule
